/* src/ple_pkg.sv */
// Shared types and codes for the positional list engine.
// Used by the control, cell, top level and checker files.
package ple_pkg;

	localparam int FUNC_W = 4;
	localparam int POS_W  = 5;
	localparam int WORD_W = 32;
	localparam int CNT_W  = 5;

	localparam logic [FUNC_W-1:0] FN_INS_FIRST = 4'd0;
	localparam logic [FUNC_W-1:0] FN_INS_LAST  = 4'd1;
	localparam logic [FUNC_W-1:0] FN_INS_AT    = 4'd2;
	localparam logic [FUNC_W-1:0] FN_READ_AT   = 4'd3;
	localparam logic [FUNC_W-1:0] FN_REM_AT    = 4'd4;
	localparam logic [FUNC_W-1:0] FN_REM_FIRST = 4'd5;
	localparam logic [FUNC_W-1:0] FN_REM_LAST  = 4'd6;
	localparam logic [FUNC_W-1:0] FN_READ_FIRST = 4'd7;
	localparam logic [FUNC_W-1:0] FN_READ_LAST = 4'd8;
	localparam logic [FUNC_W-1:0] FN_CLEAR     = 4'd9;

	localparam logic [1:0] CELL_HOLD   = 2'd0;
	localparam logic [1:0] CELL_INSERT = 2'd1;
	localparam logic [1:0] CELL_REMOVE = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [POS_W-1:0]  position;
		logic [WORD_W-1:0] item_data;
	} req_t;

	typedef struct packed {
		logic              ok;
		logic [WORD_W-1:0] data_out;
		logic [CNT_W-1:0]  count;
		logic              is_empty;
	} rsp_t;

	typedef struct packed {
		logic ok;
		logic has_data;
	} status_t;

endpackage

/* src/ple_ctrl.sv */
// Request decode and word count for the positional list engine.
// Depends on ple_pkg; drives the shared command of the cell row.
module ple_ctrl #(
	parameter int DEPTH = 16,
	parameter int LW    = 5,
	parameter int IW    = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [ple_pkg::FUNC_W-1:0] func,
	input  logic [ple_pkg::POS_W-1:0]  position,
	output logic [1:0]           cell_op,
	output logic [IW-1:0]        cell_idx,
	output ple_pkg::status_t     status,
	output logic [LW-1:0]        len_next
);

	localparam int CW = (LW > ple_pkg::POS_W) ? LW : ple_pkg::POS_W;

	logic [LW-1:0]              len_q;
	logic                       full;
	logic                       empty;
	logic                       pos_valid;
	logic [ple_pkg::POS_W-1:0]  pos_m1;
	logic [1:0]                 op;

	assign full      = (len_q == LW'(DEPTH));
	assign empty     = (len_q == '0);
	assign pos_valid = (position != '0) && (CW'(position) <= CW'(len_q));
	assign pos_m1    = position - ple_pkg::POS_W'(1);

	always_comb begin
		op              = ple_pkg::CELL_HOLD;
		cell_idx        = '0;
		status.ok       = 1'b0;
		status.has_data = 1'b0;
		len_next        = len_q;
		unique case (func)
			ple_pkg::FN_INS_FIRST: begin
				if (!full) begin
					status.ok = 1'b1;
					op        = ple_pkg::CELL_INSERT;
					len_next  = len_q + LW'(1);
				end
			end
			ple_pkg::FN_INS_LAST: begin
				if (!full) begin
					status.ok = 1'b1;
					op        = ple_pkg::CELL_INSERT;
					cell_idx  = IW'(len_q);
					len_next  = len_q + LW'(1);
				end
			end
			ple_pkg::FN_INS_AT: begin
				if (!full && (empty ? (position <= ple_pkg::POS_W'(1)) : pos_valid)) begin
					status.ok = 1'b1;
					op        = ple_pkg::CELL_INSERT;
					cell_idx  = empty ? '0 : IW'(pos_m1);
					len_next  = len_q + LW'(1);
				end
			end
			ple_pkg::FN_READ_AT: begin
				if (pos_valid) begin
					status.ok       = 1'b1;
					status.has_data = 1'b1;
					cell_idx        = IW'(pos_m1);
				end
			end
			ple_pkg::FN_REM_AT: begin
				if (pos_valid) begin
					status.ok       = 1'b1;
					status.has_data = 1'b1;
					op              = ple_pkg::CELL_REMOVE;
					cell_idx        = IW'(pos_m1);
					len_next        = len_q - LW'(1);
				end
			end
			ple_pkg::FN_REM_FIRST: begin
				if (!empty) begin
					status.ok       = 1'b1;
					status.has_data = 1'b1;
					op              = ple_pkg::CELL_REMOVE;
					len_next        = len_q - LW'(1);
				end
			end
			ple_pkg::FN_REM_LAST: begin
				if (!empty) begin
					status.ok       = 1'b1;
					status.has_data = 1'b1;
					op              = ple_pkg::CELL_REMOVE;
					cell_idx        = IW'(len_q - LW'(1));
					len_next        = len_q - LW'(1);
				end
			end
			ple_pkg::FN_READ_FIRST: begin
				if (!empty) begin
					status.ok       = 1'b1;
					status.has_data = 1'b1;
				end
			end
			ple_pkg::FN_READ_LAST: begin
				if (!empty) begin
					status.ok       = 1'b1;
					status.has_data = 1'b1;
					cell_idx        = IW'(len_q - LW'(1));
				end
			end
			ple_pkg::FN_CLEAR: begin
				status.ok = !empty;
				len_next  = '0;
			end
			default: begin
			end
		endcase
	end

	assign cell_op = accept ? op : ple_pkg::CELL_HOLD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (accept) begin
			len_q <= len_next;
		end
	end

endmodule

/* src/ple_cell.sv */
// One storage cell of the list row: holds a word, shifts with its neighbors.
// Depends on ple_pkg for the cell command codes.
module ple_cell #(
	parameter int IDX = 0,
	parameter int IW  = 4,
	parameter int DW  = 32
) (
	input  logic          clk,
	input  logic [1:0]    op,
	input  logic [IW-1:0] idx,
	input  logic [DW-1:0] word,
	input  logic [DW-1:0] left,
	input  logic [DW-1:0] right,
	output logic [DW-1:0] value,
	output logic [DW-1:0] tap
);

	localparam logic [IW-1:0] MY = IW'(IDX);

	logic [DW-1:0] val_q;

	always_ff @(posedge clk) begin
		unique case (op)
			ple_pkg::CELL_INSERT: begin
				if (MY > idx) begin
					val_q <= left;
				end else if (MY == idx) begin
					val_q <= word;
				end
			end
			ple_pkg::CELL_REMOVE: begin
				if (MY >= idx) begin
					val_q <= right;
				end
			end
			default: begin
			end
		endcase
	end

	assign value = val_q;
	assign tap   = (idx == MY) ? val_q : '0;

endmodule

/* src/positional_list_engine.sv */
// Top level of the positional list engine: request decode, cell row, result register.
// Depends on ple_pkg, ple_ctrl and ple_cell.
//
// Usage:
//   req channel (req_valid, req_stall, req) carries one command per request:
//   insert first/last/at, read at, remove at, remove first/last, read
//   first/last, clear. Positions are 1-based.
//   rsp channel (rsp_valid, rsp_stall, rsp) returns one result per request:
//   ok flag, word read or removed (zero otherwise), count and empty flag.
//   Latency: the result is valid the cycle after the request is taken.
//   Throughput: one request per cycle while no result is stalled; every
//   cell of the row shifts in the same cycle for an insert or remove anywhere in the list.
//   Read data is picked from the cell row by position before the update.
//   A stalled result holds its register; req_stall rises while a result
//   waits and rsp_stall is high, and a new request is taken in the cycle
//   the waiting result leaves.
//   Reset empties the list at once; cell contents are not cleared.
//   count shows the low five bits of the word count.
module positional_list_engine #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  ple_pkg::req_t   req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output ple_pkg::rsp_t   rsp
);

	localparam int LW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	logic                   accept;
	logic [1:0]             cell_op;
	logic [IW-1:0]          cell_idx;
	ple_pkg::status_t       status;
	logic [LW-1:0]          len_next;
	logic [DATA_WIDTH-1:0]  word;
	logic [DATA_WIDTH-1:0]  cell_val [DEPTH];
	logic [DATA_WIDTH-1:0]  cell_tap [DEPTH];
	logic [DATA_WIDTH-1:0]  rd_word;
	logic                   rsp_valid_q;
	ple_pkg::rsp_t          rsp_q;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign word      = DATA_WIDTH'(req.item_data);

	ple_ctrl #(
		.DEPTH (DEPTH),
		.LW    (LW),
		.IW    (IW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.func     (req.func),
		.position (req.position),
		.cell_op  (cell_op),
		.cell_idx (cell_idx),
		.status   (status),
		.len_next (len_next)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left;
		logic [DATA_WIDTH-1:0] right;
		if (i == 0) begin : g_first
			assign left = '0;
		end else begin : g_left
			assign left = cell_val[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right = '0;
		end else begin : g_right
			assign right = cell_val[i+1];
		end
		ple_cell #(
			.IDX (i),
			.IW  (IW),
			.DW  (DATA_WIDTH)
		) u_cell (
			.clk   (clk),
			.op    (cell_op),
			.idx   (cell_idx),
			.word  (word),
			.left  (left),
			.right (right),
			.value (cell_val[i]),
			.tap   (cell_tap[i])
		);
	end

	always_comb begin
		rd_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_word = rd_word | cell_tap[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.ok       <= status.ok;
			rsp_q.data_out <= (status.ok && status.has_data) ?
				ple_pkg::WORD_W'(rd_word) : '0;
			rsp_q.count    <= ple_pkg::CNT_W'(len_next);
			rsp_q.is_empty <= (len_next == '0);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* src/ple_chk.sv */
// Port-level checks for the positional list engine, bound to the top level.
// Depends on ple_pkg.
module ple_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input ple_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input ple_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	a_no_stall_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> !req_stall)
		else $error("request stalled with no response pending");

	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.ok |-> rsp.data_out == '0)
		else $error("failed request returned data");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.is_empty |-> rsp.count == '0)
		else $error("empty flag with nonzero count");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.func == ple_pkg::FN_CLEAR
		|=> rsp_valid && rsp.is_empty && rsp.data_out == '0)
		else $error("clear did not empty the list");

endmodule

bind positional_list_engine ple_chk u_ple_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
